### sv/parallel_port_strobe_sender_assert.svh
// Assertion macros used by the checker file.
`ifndef PARALLEL_PORT_STROBE_SENDER_ASSERT_SVH
`define PARALLEL_PORT_STROBE_SENDER_ASSERT_SVH

// Same-cycle implication, disabled while reset is held.
`define PPS_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("pps check failed");

// Next-cycle implication, disabled while reset is held.
`define PPS_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("pps check failed");

`endif

### sv/pps_pkg.sv
package pps_pkg;

    // Field widths
    localparam int DATA_W      = 8;
    localparam int CTRL_W      = 8;
    localparam int PHASE_W     = 3;
    localparam int TIMEOUT_W   = 20;
    localparam int DUR_W       = 10;
    localparam int IN_TDATA_W  = 16;
    localparam int OUT_TDATA_W = 24;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 20;

    // Command codes carried in the input tuser
    localparam logic CMD_TICK  = 1'b0;
    localparam logic CMD_WRITE = 1'b1;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_PORT_ENABLED  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT_TICKS = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SETUP_TICKS   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_STROBE_TICKS  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_HOLD_TICKS    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_CONTROL_REST  = 3'd5;

    // Register reset values
    localparam logic [TIMEOUT_W-1:0] TIMEOUT_RST = 20'd100000;
    localparam logic [DUR_W-1:0]     SETUP_RST   = 10'd10;
    localparam logic [DUR_W-1:0]     STROBE_RST  = 10'd50;
    localparam logic [DUR_W-1:0]     HOLD_RST    = 10'd10;

    // Control pin bit 0 is the strobe
    localparam logic [CTRL_W-1:0] STROBE_BIT = 8'h01;

    typedef enum logic [PHASE_W-1:0] {
        PH_IDLE   = 3'd0,
        PH_WAIT   = 3'd1,
        PH_SETUP  = 3'd2,
        PH_STROBE = 3'd3,
        PH_HOLD   = 3'd4
    } t_phase;

    // One result beat
    typedef struct packed {
        logic                rejected;
        logic                timed_out;
        logic                done_res;
        t_phase              phase;
        logic [CTRL_W-1:0]   control_pins;
        logic [DATA_W-1:0]   data_pins;
    } t_pps_res;

endpackage

### sv/pps_core.sv
module pps_core #(
    parameter int COUNT_WIDTH = 20
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_accept,
    input  logic                              i_cmd,
    input  logic [pps_pkg::DATA_W-1:0]        i_data_byte,
    input  logic                              i_not_busy_pin,
    input  logic                              i_cfg_wen,
    input  logic [pps_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [pps_pkg::CFG_DATA_W-1:0]    i_cfg_wdata,
    output pps_pkg::t_pps_res                 o_res
);

    // Compare width covers both the counter and the widest duration
    localparam int CMP_W = (COUNT_WIDTH > pps_pkg::TIMEOUT_W) ? COUNT_WIDTH
                                                               : pps_pkg::TIMEOUT_W;

    // Configuration registers
    logic                           r_enabled;
    logic [pps_pkg::TIMEOUT_W-1:0]  r_timeout;
    logic [pps_pkg::DUR_W-1:0]      r_setup;
    logic [pps_pkg::DUR_W-1:0]      r_strobe;
    logic [pps_pkg::DUR_W-1:0]      r_hold;
    logic [pps_pkg::CTRL_W-1:0]     r_ctrl_rest;

    // Transfer state
    pps_pkg::t_phase                r_phase, n_phase;
    logic [COUNT_WIDTH-1:0]         r_count, n_count;
    logic [pps_pkg::DATA_W-1:0]     r_latch, n_latch;
    logic                           n_done, n_tmo, n_rej;

    logic [pps_pkg::TIMEOUT_W-1:0]  dur_raw;
    logic [CMP_W-1:0]               dur_ext;
    logic [CMP_W-1:0]               dur_clamp;
    logic [CMP_W-1:0]               cnt_max_ext;
    logic [COUNT_WIDTH-1:0]         cnt_inc;
    logic                           reached;

    // Configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_enabled   <= 1'b0;
            r_timeout   <= pps_pkg::TIMEOUT_RST;
            r_setup     <= pps_pkg::SETUP_RST;
            r_strobe    <= pps_pkg::STROBE_RST;
            r_hold      <= pps_pkg::HOLD_RST;
            r_ctrl_rest <= '0;
        end else if (i_cfg_wen) begin
            unique case (i_cfg_index)
                pps_pkg::CFG_PORT_ENABLED:  r_enabled   <= i_cfg_wdata[0];
                pps_pkg::CFG_TIMEOUT_TICKS: r_timeout   <= i_cfg_wdata;
                pps_pkg::CFG_SETUP_TICKS:   r_setup     <= i_cfg_wdata[pps_pkg::DUR_W-1:0];
                pps_pkg::CFG_STROBE_TICKS:  r_strobe    <= i_cfg_wdata[pps_pkg::DUR_W-1:0];
                pps_pkg::CFG_HOLD_TICKS:    r_hold      <= i_cfg_wdata[pps_pkg::DUR_W-1:0];
                pps_pkg::CFG_CONTROL_REST:  r_ctrl_rest <= i_cfg_wdata[pps_pkg::CTRL_W-1:0];
                default: ;
            endcase
        end
    end

    // Duration of the current phase; timeout and strobe count at least one tick
    always_comb begin
        case (r_phase)
            pps_pkg::PH_WAIT:   dur_raw = r_timeout;
            pps_pkg::PH_SETUP:  dur_raw = pps_pkg::TIMEOUT_W'(r_setup);
            pps_pkg::PH_STROBE: dur_raw = pps_pkg::TIMEOUT_W'(r_strobe);
            pps_pkg::PH_HOLD:   dur_raw = pps_pkg::TIMEOUT_W'(r_hold);
            default:            dur_raw = '0;
        endcase
        if ((r_phase == pps_pkg::PH_WAIT || r_phase == pps_pkg::PH_STROBE) &&
            dur_raw == '0) begin
            dur_raw = pps_pkg::TIMEOUT_W'(1);
        end
    end

    // Clamp to the counter range, saturating increment, end-of-phase compare
    assign dur_ext     = CMP_W'(dur_raw);
    assign cnt_max_ext = CMP_W'({COUNT_WIDTH{1'b1}});
    assign dur_clamp   = (dur_ext > cnt_max_ext) ? cnt_max_ext : dur_ext;
    assign cnt_inc     = (&r_count) ? r_count : r_count + COUNT_WIDTH'(1);
    assign reached     = CMP_W'(cnt_inc) >= dur_clamp;

    // Next state
    always_comb begin
        n_phase = r_phase;
        n_count = r_count;
        n_latch = r_latch;
        n_done  = 1'b0;
        n_tmo   = 1'b0;
        n_rej   = 1'b0;
        if (i_cmd == pps_pkg::CMD_WRITE) begin
            if (!r_enabled || r_phase != pps_pkg::PH_IDLE) begin
                n_rej = 1'b1;
            end else begin
                n_latch = i_data_byte;
                n_phase = pps_pkg::PH_WAIT;
                n_count = '0;
            end
        end else begin
            unique case (r_phase)
                pps_pkg::PH_IDLE: ;
                pps_pkg::PH_WAIT: begin
                    // a ready sample always wins over the timeout
                    if (i_not_busy_pin) begin
                        n_count = '0;
                        n_phase = (r_setup == '0) ? pps_pkg::PH_STROBE : pps_pkg::PH_SETUP;
                    end else if (reached) begin
                        n_tmo   = 1'b1;
                        n_phase = pps_pkg::PH_IDLE;
                        n_count = '0;
                    end else begin
                        n_count = cnt_inc;
                    end
                end
                pps_pkg::PH_SETUP: begin
                    if (reached) begin
                        n_count = '0;
                        n_phase = pps_pkg::PH_STROBE;
                    end else begin
                        n_count = cnt_inc;
                    end
                end
                pps_pkg::PH_STROBE: begin
                    if (reached) begin
                        n_count = '0;
                        // zero hold ends the transfer with the strobe
                        if (r_hold == '0) begin
                            n_phase = pps_pkg::PH_IDLE;
                            n_done  = 1'b1;
                        end else begin
                            n_phase = pps_pkg::PH_HOLD;
                        end
                    end else begin
                        n_count = cnt_inc;
                    end
                end
                pps_pkg::PH_HOLD: begin
                    if (reached) begin
                        n_count = '0;
                        n_phase = pps_pkg::PH_IDLE;
                        n_done  = 1'b1;
                    end else begin
                        n_count = cnt_inc;
                    end
                end
                default: begin
                    n_phase = pps_pkg::PH_IDLE;
                    n_count = '0;
                end
            endcase
        end
    end

    // Pin outputs show the state after this beat
    always_comb begin
        o_res.data_pins    = '0;
        o_res.control_pins = r_ctrl_rest & ~pps_pkg::STROBE_BIT;
        case (n_phase)
            pps_pkg::PH_SETUP, pps_pkg::PH_HOLD: begin
                o_res.data_pins = n_latch;
            end
            pps_pkg::PH_STROBE: begin
                o_res.data_pins    = n_latch;
                o_res.control_pins = o_res.control_pins | pps_pkg::STROBE_BIT;
            end
            default: ;
        endcase
        o_res.phase     = n_phase;
        o_res.done_res  = n_done;
        o_res.timed_out = n_tmo;
        o_res.rejected  = n_rej;
    end

    // State update on each accepted beat
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= pps_pkg::PH_IDLE;
            r_count <= '0;
            r_latch <= '0;
        end else if (i_accept) begin
            r_phase <= n_phase;
            r_count <= n_count;
            r_latch <= n_latch;
        end
    end

endmodule

### sv/parallel_port_strobe_sender.sv
// Parallel-port byte sender with a strobe handshake.
// Input stream: tuser is the command (0 tick with a pin sample, 1 write a byte);
// tdata carries the byte and the sampled not-busy pin. A write starts a transfer:
// wait for not-busy (timeout after the set tick count), drive data for the setup
// time, pulse strobe for the strobe width, hold data for the hold time.
// Output stream: one result beat per input beat, showing the data pins, control
// pins (bit 0 strobe), phase, and done / timeout / reject flags.
// The result is registered at the edge that takes the input beat. Throughput is
// one beat per cycle while the receiver does not stall; the next-state logic of the
// transfer counter and phase machine is the only path between the registers.
// When the receiver stalls, the result register holds its beat and the input
// side takes a new beat in the same cycle the held one is taken.
// The user must write configuration registers through the plain write port while
// the block is idle (not enforced by the block). Reset clears the phase machine, the
// counter, the byte latch and the output valid, and loads the register defaults (port disabled).
module parallel_port_strobe_sender #(
    parameter int COUNT_WIDTH = 20
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // input stream
    input  logic                                i_s_tvalid,
    output logic                                o_s_tready,
    input  logic [pps_pkg::IN_TDATA_W-1:0]      i_s_tdata,   // [7:0] data_byte, [8] not_busy_pin
    input  logic                                i_s_tuser,   // [0] cmd
    // output stream
    output logic                                o_m_tvalid,
    input  logic                                i_m_tready,
    output logic [pps_pkg::OUT_TDATA_W-1:0]     o_m_tdata,   // [7:0] data_pins, [15:8] control_pins,
                                                             // [18:16] phase, [19] done_res,
                                                             // [20] timed_out, [21] rejected
    // configuration
    input  logic                                i_cfg_wen,
    input  logic [pps_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [pps_pkg::CFG_DATA_W-1:0]      i_cfg_wdata
);

    logic              in_accept;
    pps_pkg::t_pps_res core_res;
    pps_pkg::t_pps_res r_res;
    logic              r_valid;

    // The result register frees up when empty or when its beat is taken
    assign o_s_tready = !r_valid || i_m_tready;
    assign in_accept  = i_s_tvalid && o_s_tready;

    pps_core #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_core (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_accept       (in_accept),
        .i_cmd          (i_s_tuser),
        .i_data_byte    (i_s_tdata[pps_pkg::DATA_W-1:0]),
        .i_not_busy_pin (i_s_tdata[pps_pkg::DATA_W]),
        .i_cfg_wen      (i_cfg_wen),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_wdata    (i_cfg_wdata),
        .o_res          (core_res)
    );

    // Output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_s_tready) begin
            r_valid <= i_s_tvalid;
        end
    end

    // Output payload
    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_res <= core_res;
        end
    end

    assign o_m_tvalid = r_valid;
    assign o_m_tdata  = pps_pkg::OUT_TDATA_W'(r_res);

endmodule

### sv/pps_checker.sv
`include "parallel_port_strobe_sender_assert.svh"

module pps_checker (
    input logic                                i_clk,
    input logic                                i_rst_n,
    input logic                                o_m_tvalid,
    input logic                                i_m_tready,
    input logic [pps_pkg::OUT_TDATA_W-1:0]     o_m_tdata
);

    logic [pps_pkg::PHASE_W-1:0] phase;
    logic                        strobe;
    logic [pps_pkg::DATA_W-1:0]  data_pins;
    logic [2:0]                  flags;
    logic                        quiet;

    assign data_pins = o_m_tdata[7:0];
    assign strobe    = o_m_tdata[8];
    assign phase     = o_m_tdata[18:16];
    assign flags     = o_m_tdata[21:19];
    assign quiet     = (phase == pps_pkg::PH_IDLE) || (phase == pps_pkg::PH_WAIT);

    // A stalled result beat stays put
    `PPS_ASSERT_NXT(a_stall_hold, i_clk, i_rst_n, o_m_tvalid && !i_m_tready, o_m_tvalid && $stable(o_m_tdata))

    // Done, timeout and reject never come together
    `PPS_ASSERT_IMP(a_flags_excl, i_clk, i_rst_n, o_m_tvalid, $countones(flags) <= 1)

    // Strobe is high exactly in the strobe phase
    `PPS_ASSERT_IMP(a_strobe_phase, i_clk, i_rst_n, o_m_tvalid, strobe == (phase == pps_pkg::PH_STROBE))

    // Data lines are quiet while not driving
    `PPS_ASSERT_IMP(a_data_quiet, i_clk, i_rst_n, o_m_tvalid && quiet, data_pins == '0)

endmodule

bind parallel_port_strobe_sender pps_checker u_pps_checker (.*);
